@@ rtl/pbd_pkg.sv @@
`timescale 1ns / 1ps

package pbd_pkg;

   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_RETIRE = 2'd2;

   localparam logic [1:0] STATUS_RAM    = 2'd0;
   localparam logic [1:0] STATUS_TIMER  = 2'd1;
   localparam logic [1:0] STATUS_SERIAL = 2'd2;
   localparam logic [1:0] STATUS_FAULT  = 2'd3;

   localparam logic [31:0] SERIAL_ADDR_A = 32'ha000_03f8;
   localparam logic [31:0] SERIAL_ADDR_B = 32'h1000_0000;
   localparam logic [15:0] TIMER_PAGE    = 16'h0200;
   localparam logic [31:0] TIME_LOW_ADDR  = 32'h0200_bff8;
   localparam logic [31:0] TIME_HIGH_ADDR = 32'h0200_bffc;

   localparam logic [31:0] RAM_BASE_RESET = 32'h8000_0000;

   localparam int LANES = 4;

   typedef logic [7:0] byte_type;

endpackage

@@ rtl/physical_bus_decoder_with_ram.sv @@
`timescale 1ns / 1ps

// Bus address decoder with a little-endian byte RAM. One request beat is taken every cycle
// while the result side keeps up; a result passes the registered read of the RAM banks in
// stage one, then the output register. The RAM is split into four byte-wide banks with one
// read or write port each, so any 1-, 2- or 4-byte access, aligned or not, touches each bank
// at most once. RAM contents are undefined after reset and need no clearing pass: software
// must write a location before reading it. Reads of the machine-time words return halves of
// a 64-bit retired-instruction counter. The user must write the base of the RAM window
// through the csr port only while the block is idle; the block itself does not enforce this.
module physical_bus_decoder_with_ram
   import pbd_pkg::*;
#(
   parameter int RAM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_ram_base,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_address,
   input  logic [2:0]  req_access_bytes,
   input  logic [31:0] req_write_data,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_status,
   output logic        rsp_serial_valid,
   output logic [7:0]  rsp_serial_byte
);

   localparam int BankDepth = (RAM_BYTES + LANES - 1) / LANES;
   localparam int RowW = $clog2(BankDepth);
   localparam logic [32:0] RamLimit = 33'(RAM_BYTES);

   logic [31:0] ram_base_ff;
   logic [63:0] retired_ff;

   // stage one: decoded beat waiting for bank read data
   logic        s1_valid_ff;
   logic        s1_ram_read_ff;
   logic [1:0]  s1_off_lo_ff;
   logic [2:0]  s1_len_ff;
   logic [31:0] s1_rdata_ff;
   logic [1:0]  s1_status_ff;
   logic        s1_svalid_ff;
   logic [7:0]  s1_sbyte_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_rdata_ff;
   logic [1:0]  rsp_status_ff;
   logic        rsp_svalid_ff;
   logic [7:0]  rsp_sbyte_ff;

   logic        req_accept;
   logic        s1_adv;

   logic        len_ok;
   logic [31:0] off;
   logic [32:0] off_end;
   logic        fits;
   logic        is_serial;
   logic        in_timer;
   logic [RowW-1:0] row;

   logic        s1_ram_read_in;
   logic [31:0] s1_rdata_in;
   logic [1:0]  s1_status_in;
   logic        s1_svalid_in;
   logic [7:0]  s1_sbyte_in;

   logic [RowW-1:0] bank_row [LANES];
   logic            bank_we [LANES];
   byte_type        bank_wdata [LANES];
   byte_type        bank_rd_ff [LANES];

   logic [31:0] ram_rdata;

   assign csr_ready = 1'b1;
   assign s1_adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_accept = req_valid && req_ready;

   // request decode
   always_comb begin
      len_ok = (req_access_bytes == 3'd1) || (req_access_bytes == 3'd2)
            || (req_access_bytes == 3'd4);
      off = req_address - ram_base_ff;
      off_end = {1'b0, off} + 33'(req_access_bytes);
      fits = ({1'b0, off} < RamLimit) && (off_end <= RamLimit);
      is_serial = (req_address == SERIAL_ADDR_A) || (req_address == SERIAL_ADDR_B);
      in_timer = (req_address[31:16] == TIMER_PAGE);
      row = off[RowW+1:2];

      s1_ram_read_in = 1'b0;
      s1_rdata_in = '0;
      s1_status_in = STATUS_RAM;
      s1_svalid_in = 1'b0;
      s1_sbyte_in = '0;
      if (req_type == KIND_READ || req_type == KIND_WRITE) begin
         if (!len_ok) begin
            s1_status_in = STATUS_FAULT;
         end else if (fits) begin
            s1_ram_read_in = (req_type == KIND_READ);
         end else if (req_type == KIND_READ && req_address == TIME_LOW_ADDR) begin
            s1_status_in = STATUS_TIMER;
            s1_rdata_in = retired_ff[31:0];
         end else if (req_type == KIND_READ && req_address == TIME_HIGH_ADDR) begin
            s1_status_in = STATUS_TIMER;
            s1_rdata_in = retired_ff[63:32];
         end else if (in_timer) begin
            s1_status_in = STATUS_TIMER;
         end else if (is_serial && req_access_bytes == 3'd1) begin
            s1_status_in = STATUS_SERIAL;
            if (req_type == KIND_WRITE) begin
               s1_svalid_in = 1'b1;
               s1_sbyte_in = req_write_data[7:0];
            end
         end else begin
            s1_status_in = STATUS_FAULT;
         end
      end
   end

   // per-bank row and write lane
   always_comb begin
      logic [1:0] lane;
      for (int b = 0; b < LANES; b++) begin
         lane = 2'(b) - off[1:0];
         bank_row[b] = (2'(b) < off[1:0]) ? row + RowW'(1) : row;
         bank_we[b] = req_accept && (req_type == KIND_WRITE) && len_ok && fits
                   && ({1'b0, lane} < req_access_bytes);
         bank_wdata[b] = req_write_data[8*lane +: 8];
      end
   end

   for (genvar b = 0; b < LANES; b++) begin : g_bank
      byte_type bank_mem [BankDepth];

      always_ff @(posedge clock) begin
         if (bank_we[b]) begin
            bank_mem[bank_row[b]] <= bank_wdata[b];
         end
         if (req_accept) begin
            bank_rd_ff[b] <= bank_mem[bank_row[b]];
         end
      end
   end

   // rotate bank bytes back into access order
   always_comb begin
      logic [1:0] bank;
      for (int i = 0; i < LANES; i++) begin
         bank = 2'(i) + s1_off_lo_ff;
         ram_rdata[8*i +: 8] = (3'(i) < s1_len_ff) ? bank_rd_ff[bank] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_base_ff <= RAM_BASE_RESET;
         retired_ff <= '0;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            ram_base_ff <= csr_ram_base;
         end
         if (req_accept && req_type == KIND_RETIRE) begin
            retired_ff <= retired_ff + 64'd1;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ram_read_ff <= s1_ram_read_in;
         s1_off_lo_ff <= off[1:0];
         s1_len_ff <= req_access_bytes;
         s1_rdata_ff <= s1_rdata_in;
         s1_status_ff <= s1_status_in;
         s1_svalid_ff <= s1_svalid_in;
         s1_sbyte_ff <= s1_sbyte_in;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_rdata_ff <= s1_ram_read_ff ? ram_rdata : s1_rdata_ff;
         rsp_status_ff <= s1_status_ff;
         rsp_svalid_ff <= s1_svalid_ff;
         rsp_sbyte_ff <= s1_sbyte_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_rdata_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_serial_valid = rsp_svalid_ff;
   assign rsp_serial_byte = rsp_sbyte_ff;

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted beat not held in stage one");

   a_s1_holds : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("stalled beat dropped from stage one");

   a_retire_counts : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_type == KIND_RETIRE |=> retired_ff == $past(retired_ff) + 64'd1)
      else $error("retired counter did not advance");

   a_serial_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_svalid_ff |-> rsp_status_ff == STATUS_SERIAL)
      else $error("serial byte emitted with wrong status");

   a_rdata_source : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rdata_ff != '0
         |-> rsp_status_ff == STATUS_RAM || rsp_status_ff == STATUS_TIMER)
      else $error("read data on serial or fault beat");

endmodule
